/* rtl/adc_mah_pkg.sv */
`default_nettype none

package adc_mah_pkg;

    localparam int CH_W        = 3;
    localparam int SAMPLE_W    = 12;
    localparam int BAND_W      = 8;
    localparam int LIMIT_W     = 16;
    localparam int ACC_W       = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_HALFWIDTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIFT_LIMIT    = 1'b1;

    localparam logic [BAND_W-1:0]  BAND_RESET  = 8'd15;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] held;
        logic [ACC_W-1:0]    above;
        logic [ACC_W-1:0]    below;
    } chan_rec_t;

endpackage

`default_nettype wire

/* rtl/adc_mah_if.sv */
`default_nettype none

interface adc_mah_in_if;
    import adc_mah_pkg::*;

    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface adc_mah_out_if;
    import adc_mah_pkg::*;

    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] raw_value;
    logic [SAMPLE_W-1:0] smooth_value;

    modport source (output valid, output out_channel, output raw_value,
                    output smooth_value, input ready);
    modport sink   (input valid, input out_channel, input raw_value,
                    input smooth_value, output ready);
endinterface

`default_nettype wire

/* rtl/adc_moving_average_hysteresis_top.sv */
`default_nettype none

// Channel    Direction  Width (bits)             Transfer
// samples    sink       channel 3, sample 12     valid && ready
// results    source     3 + 12 + 12              valid && ready
// cfg        write      index 1, data 16         cfg_wr_en
//
// Samples on different channels are taken one per cycle while the result
// stage is not stalled; a sample on the same channel as the one ahead of it
// waits in stage C until that one leaves stage D, set by the two-stage
// read-modify-write loop on the channel record memory.
// Reset needs no clearing pass: per-channel fill and valid flags make unwritten
// entries read as zero. A stalled result stage freezes only the stages behind
// it that are full.

module adc_moving_average_hysteresis_top #(
    parameter int CHANNELS   = 8,
    parameter int RING_DEPTH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    adc_mah_in_if.sink                                samples,
    adc_mah_out_if.source                             results,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [adc_mah_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [adc_mah_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import adc_mah_pkg::*;

    localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W  = $clog2(RING_DEPTH);
    localparam int SUM_W   = SAMPLE_W + SLOT_W;
    localparam int SHIFT   = SUM_W + SLOT_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [SAMPLE_W-1:0] d);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + (ACC_W+1)'(d);
        sat_add = s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    // configuration
    logic [BAND_W-1:0]  band_reg;
    logic [LIMIT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg  <= BAND_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BAND_HALFWIDTH: band_reg  <= cfg_wdata[BAND_W-1:0];
                CFG_DRIFT_LIMIT:    limit_reg <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, o_vld_reg;
    logic accept, a_go, b_go, c_go, d_go;
    logic a_free, b_free, c_free, d_free, o_free;
    logic c_hazard, d_write;

    logic [CH_W-1:0] a_ch_reg, b_ch_reg, c_ch_reg, d_ch_reg, o_ch_reg;

    assign o_free   = !o_vld_reg || results.ready;
    assign d_go     = d_vld_reg && o_free;
    assign d_free   = !d_vld_reg || o_free;
    assign c_hazard = d_vld_reg && (d_ch_reg == c_ch_reg);
    assign c_go     = c_vld_reg && d_free && !c_hazard;
    assign c_free   = !c_vld_reg || (d_free && !c_hazard);
    assign b_go     = b_vld_reg && c_free;
    assign b_free   = !b_vld_reg || c_free;
    assign a_go     = a_vld_reg && b_free;
    assign a_free   = !a_vld_reg || b_free;

    assign samples.ready = a_free;
    assign accept        = samples.valid && a_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_free) a_vld_reg <= accept;
            if (b_free) b_vld_reg <= a_go;
            if (c_free) c_vld_reg <= b_go;
            if (d_free) d_vld_reg <= c_go;
            if (o_free) o_vld_reg <= d_go;
        end
    end

    // input decode, ring slot and fill flags
    logic [IDX_W-1:0]  in_idx;
    logic              in_live;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] slot_reg [CHANNELS];
    logic [CHANNELS-1:0] full_reg;

    assign in_idx  = IDX_W'(samples.channel);
    assign in_live = int'(samples.channel) < CHANNELS;
    assign in_slot = slot_reg[in_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                slot_reg[i] <= '0;
            end
            full_reg <= '0;
        end
        else if (accept && in_live)
        begin
            if (in_slot == SLOT_LAST)
            begin
                slot_reg[in_idx] <= '0;
                full_reg[in_idx] <= 1'b1;
            end
            else
            begin
                slot_reg[in_idx] <= in_slot + 1'b1;
            end
        end
    end

    // sample ring memory: write new, read oldest in one access
    logic [SAMPLE_W-1:0] ring_mem [CHANNELS][RING_DEPTH];
    logic [SAMPLE_W-1:0] a_old_reg;
    logic [SAMPLE_W-1:0] a_smp_reg;
    logic                a_live_reg;
    logic                a_full_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (in_live)
            begin
                ring_mem[in_idx][in_slot] <= samples.sample;
            end
            a_old_reg <= ring_mem[in_idx][in_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_ch_reg   <= samples.channel;
            a_smp_reg  <= samples.sample;
            a_live_reg <= in_live;
            a_full_reg <= full_reg[in_idx];
        end
    end

    // stage A: running sum
    logic [IDX_W-1:0]    a_idx;
    logic [SAMPLE_W-1:0] a_old;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    sum_reg [CHANNELS];

    assign a_idx    = IDX_W'(a_ch_reg);
    assign a_old    = a_full_reg ? a_old_reg : '0;
    assign sum_next = sum_reg[a_idx] - SUM_W'(a_old) + SUM_W'(a_smp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (a_go && a_live_reg)
        begin
            sum_reg[a_idx] <= sum_next;
        end
    end

    logic [SAMPLE_W-1:0] b_smp_reg;
    logic                b_live_reg;
    logic [SUM_W-1:0]    b_sum_reg;

    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            b_ch_reg   <= a_ch_reg;
            b_smp_reg  <= a_smp_reg;
            b_live_reg <= a_live_reg;
            b_sum_reg  <= sum_next;
        end
    end

    // stage B: reciprocal multiply, channel record read
    logic [IDX_W-1:0]    b_idx;
    logic [PROD_W-1:0]   c_prod_reg;
    logic [SAMPLE_W-1:0] c_smp_reg;
    logic                c_live_reg;

    assign b_idx = IDX_W'(b_ch_reg);

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            c_ch_reg   <= b_ch_reg;
            c_smp_reg  <= b_smp_reg;
            c_live_reg <= b_live_reg;
            c_prod_reg <= b_sum_reg * RECIP;
        end
    end

    chan_rec_t           chan_mem [CHANNELS];
    chan_rec_t           chan_rd_reg;
    chan_rec_t           c_fwd_reg;
    chan_rec_t           d_rec_next;
    logic [CHANNELS-1:0] rec_vld_reg;
    logic                c_mem_vld_reg;
    logic                c_fwd_vld_reg;
    logic                fwd_hit;
    logic [IDX_W-1:0]    d_idx;
    logic                d_live_reg;

    assign d_idx   = IDX_W'(d_ch_reg);
    assign d_write = d_go && d_live_reg;
    assign fwd_hit = d_write && (b_go ? (d_ch_reg == b_ch_reg) : (d_ch_reg == c_ch_reg));

    always_ff @(posedge clk)
    begin
        if (d_write)
        begin
            chan_mem[d_idx] <= d_rec_next;
        end
        if (b_go)
        begin
            chan_rd_reg <= chan_mem[b_idx];
        end
        if (fwd_hit)
        begin
            c_fwd_reg <= d_rec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_vld_reg   <= '0;
            c_mem_vld_reg <= 1'b0;
            c_fwd_vld_reg <= 1'b0;
        end
        else
        begin
            if (d_write)
            begin
                rec_vld_reg[d_idx] <= 1'b1;
            end
            if (b_go)
            begin
                c_mem_vld_reg <= rec_vld_reg[b_idx];
                c_fwd_vld_reg <= fwd_hit;
            end
            else if (fwd_hit)
            begin
                c_fwd_vld_reg <= 1'b1;
            end
        end
    end

    // stage C: band test and accumulation
    chan_rec_t           c_rec;
    logic [SAMPLE_W-1:0] c_avg;
    logic [SAMPLE_W-1:0] c_lo;
    logic [SAMPLE_W:0]   c_hi;
    logic                c_pass;
    logic [ACC_W-1:0]    c_above;
    logic [ACC_W-1:0]    c_below;

    always_comb
    begin
        if (c_fwd_vld_reg)
            c_rec = c_fwd_reg;
        else if (c_mem_vld_reg)
            c_rec = chan_rd_reg;
        else
            c_rec = '0;

        c_avg = c_prod_reg[SHIFT +: SAMPLE_W];
        c_lo  = (c_rec.held >= SAMPLE_W'(band_reg)) ? c_rec.held - SAMPLE_W'(band_reg) : '0;
        c_hi  = {1'b0, c_rec.held} + (SAMPLE_W+1)'(band_reg);
        c_pass = !((c_avg > c_lo) && ({1'b0, c_avg} < c_hi));

        c_above = (c_avg > c_rec.held) ? sat_add(c_rec.above, c_avg - c_rec.held)
                                       : c_rec.above;
        c_below = (c_avg < c_rec.held) ? sat_add(c_rec.below, c_rec.held - c_avg)
                                       : c_rec.below;
    end

    logic [SAMPLE_W-1:0] d_smp_reg;
    logic [SAMPLE_W-1:0] d_avg_reg;
    logic [SAMPLE_W-1:0] d_held_reg;
    logic [ACC_W-1:0]    d_above_reg;
    logic [ACC_W-1:0]    d_below_reg;
    logic                d_pass_reg;

    always_ff @(posedge clk)
    begin
        if (c_go)
        begin
            d_ch_reg    <= c_ch_reg;
            d_smp_reg   <= c_smp_reg;
            d_live_reg  <= c_live_reg;
            d_avg_reg   <= c_avg;
            d_held_reg  <= c_rec.held;
            d_above_reg <= c_above;
            d_below_reg <= c_below;
            d_pass_reg  <= c_pass;
        end
    end

    // stage D: drift correction and write back
    logic                d_up;
    logic                d_dn;
    logic [SAMPLE_W-1:0] d_smooth;

    always_comb
    begin
        d_up = {1'b0, d_above_reg} > ({1'b0, d_below_reg} + {1'b0, limit_reg});
        d_dn = {1'b0, d_below_reg} > ({1'b0, d_above_reg} + {1'b0, limit_reg});

        d_rec_next.above = '0;
        d_rec_next.below = '0;
        if (d_pass_reg)
        begin
            d_rec_next.held = d_avg_reg;
        end
        else if (d_up)
        begin
            d_rec_next.held = (d_held_reg == SAMPLE_MAX) ? SAMPLE_MAX : d_held_reg + 1'b1;
        end
        else if (d_dn)
        begin
            d_rec_next.held = (d_held_reg == '0) ? '0 : d_held_reg - 1'b1;
        end
        else
        begin
            d_rec_next.held  = d_held_reg;
            d_rec_next.above = d_above_reg;
            d_rec_next.below = d_below_reg;
        end

        d_smooth = d_live_reg ? d_rec_next.held : '0;
    end

    // result register
    logic [SAMPLE_W-1:0] o_raw_reg;
    logic [SAMPLE_W-1:0] o_smooth_reg;

    always_ff @(posedge clk)
    begin
        if (d_go)
        begin
            o_ch_reg     <= d_ch_reg;
            o_raw_reg    <= d_smp_reg;
            o_smooth_reg <= d_smooth;
        end
    end

    assign results.valid        = o_vld_reg;
    assign results.out_channel  = o_ch_reg;
    assign results.raw_value    = o_raw_reg;
    assign results.smooth_value = o_smooth_reg;

endmodule

`default_nettype wire

/* test/adc_mah_filter_checker.sv */
`default_nettype none

module adc_mah_filter_checker
    import adc_mah_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int RING_DEPTH = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    adc_mah_in_if                       samples,
    adc_mah_out_if                      results,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                          pending_count,
    output int                          error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int unsigned ACCUM_MAX  = (1 << ACC_W) - 1;

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] raw;
        logic [SAMPLE_W-1:0] smooth;
    } smoothed_word_t;

    smoothed_word_t smoothed_fifo[$];
    smoothed_word_t want;
    smoothed_word_t got;

    int unsigned ring_mem [CHANNELS][RING_DEPTH];
    int unsigned ring_pos   [CHANNELS];
    int unsigned ring_total [CHANNELS];
    int unsigned held_level [CHANNELS];
    int unsigned above_sum  [CHANNELS];
    int unsigned below_sum  [CHANNELS];
    int unsigned band_cfg;
    int unsigned limit_cfg;
    int          mismatches;

    function automatic int unsigned accum_add(input int unsigned acc, input int unsigned d);
        return (acc + d > ACCUM_MAX) ? ACCUM_MAX : acc + d;
    endfunction

    function automatic smoothed_word_t filter_sample(input logic [CH_W-1:0] ch,
                                                     input logic [SAMPLE_W-1:0] s);
        smoothed_word_t r;
        int unsigned    slot;
        int unsigned    avg;
        int unsigned    held;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    next_held;
        r.channel = ch;
        r.raw     = s;
        r.smooth  = '0;
        if (int'(ch) < CHANNELS)
        begin
            slot = ring_pos[ch];
            ring_total[ch]     = ring_total[ch] - ring_mem[ch][slot] + s;
            ring_mem[ch][slot] = s;
            ring_pos[ch]       = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
            avg  = ring_total[ch] / RING_DEPTH;
            held = held_level[ch];
            lo   = (held >= band_cfg) ? held - band_cfg : 0;
            hi   = held + band_cfg;
            if (!(avg > lo && avg < hi))
            begin
                above_sum[ch] = 0;
                below_sum[ch] = 0;
                next_held     = avg & SAMPLE_MAX;
            end
            else
            begin
                if (avg > held)
                    above_sum[ch] = accum_add(above_sum[ch], avg - held);
                if (avg < held)
                    below_sum[ch] = accum_add(below_sum[ch], held - avg);
                next_held = held;
                if (above_sum[ch] > below_sum[ch] + limit_cfg)
                begin
                    above_sum[ch] = 0;
                    below_sum[ch] = 0;
                    next_held     = (held < SAMPLE_MAX) ? held + 1 : SAMPLE_MAX;
                end
                else if (below_sum[ch] > above_sum[ch] + limit_cfg)
                begin
                    above_sum[ch] = 0;
                    below_sum[ch] = 0;
                    next_held     = (held > 0) ? held - 1 : 0;
                end
            end
            held_level[ch] = next_held;
            r.smooth       = next_held[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int d = 0; d < RING_DEPTH; d++)
                    ring_mem[c][d] = 0;
                ring_pos[c]   = 0;
                ring_total[c] = 0;
                held_level[c] = 0;
                above_sum[c]  = 0;
                below_sum[c]  = 0;
            end
            band_cfg   = BAND_RESET;
            limit_cfg  = LIMIT_RESET;
            mismatches = 0;
            smoothed_fifo.delete();
            pending_count <= 0;
            error_count   <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got.channel = results.out_channel;
                got.raw     = results.raw_value;
                got.smooth  = results.smooth_value;
                if (smoothed_fifo.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result ch=%0d raw=%0d smooth=%0d",
                                 $realtime, got.channel, got.raw, got.smooth);
                end
                else
                begin
                    want = smoothed_fifo.pop_front();
                    if (got.channel !== want.channel || got.raw !== want.raw
                        || got.smooth !== want.smooth)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp ch=%0d raw=%0d smooth=%0d, got ch=%0d raw=%0d smooth=%0d",
                                     $realtime, want.channel, want.raw, want.smooth,
                                     got.channel, got.raw, got.smooth);
                    end
                end
            end
            if (samples.valid && samples.ready)
                smoothed_fifo.push_back(filter_sample(samples.channel, samples.sample));
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_BAND_HALFWIDTH)
                    band_cfg = cfg_wdata[BAND_W-1:0];
                else if (cfg_index == CFG_DRIFT_LIMIT)
                    limit_cfg = cfg_wdata[LIMIT_W-1:0];
            end
            pending_count <= smoothed_fifo.size();
            error_count   <= mismatches;
        end
    end

endmodule

`default_nettype wire

/* test/adc_moving_average_hysteresis_top_tb.sv */
`default_nettype none

module adc_moving_average_hysteresis_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adc_mah_pkg::*;

    localparam int CHANNELS   = 8;
    localparam int RING_DEPTH = 8;
    localparam int SAMPLE_TOP = (1 << SAMPLE_W) - 1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    int                     pending_count;
    int                     error_count;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     level [CHANNELS];

    adc_mah_in_if  samples_if ();
    adc_mah_out_if results_if ();

    adc_moving_average_hysteresis_top #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .results   (results_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    adc_mah_filter_checker #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples_if),
        .results       (results_if),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .pending_count (pending_count),
        .error_count   (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        results_if.ready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
        while (int'($urandom_range(0, 99)) < send_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid   <= 1'b1;
        samples_if.channel <= ch;
        samples_if.sample  <= s;
        do
            @(posedge clk);
        while (!samples_if.ready);
    endtask

    // hold the stream until every result has come back
    task automatic drain_results();
        samples_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    task automatic configure(input int band, input int limit);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BAND_HALFWIDTH;
        cfg_wdata <= CFG_DATA_W'(band);
        @(posedge clk);
        cfg_index <= CFG_DRIFT_LIMIT;
        cfg_wdata <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int hot_chan, input int hot_pct,
                             input int lo_off, input int hi_off);
        int ch;
        int pick;
        int v;
        for (int n = 0; n < count; n++)
        begin
            if (hot_chan >= 0 && int'($urandom_range(0, 99)) < hot_pct)
                ch = hot_chan;
            else
                ch = $urandom_range(0, CHANNELS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 4)
                level[ch] = $urandom_range(0, SAMPLE_TOP);
            if (pick < 78)
            begin
                v = level[ch] + lo_off + int'($urandom_range(0, hi_off - lo_off));
                v = (v < 0) ? 0 : (v > SAMPLE_TOP) ? SAMPLE_TOP : v;
            end
            else if (pick < 86)
                v = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
            else
                v = $urandom_range(0, SAMPLE_TOP);
            send_sample(CH_W'(ch), SAMPLE_W'(v));
            if ($urandom_range(0, 149) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        int band;
        rst_n              = 1'b0;
        samples_if.valid   = 1'b0;
        samples_if.channel = '0;
        samples_if.sample  = '0;
        results_if.ready   = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_BAND_HALFWIDTH;
        cfg_wdata          = '0;
        send_idle_pct      = 30;
        recv_idle_pct      = 72;
        for (int c = 0; c < CHANNELS; c++)
            level[c] = $urandom_range(0, SAMPLE_TOP);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes, floor of the band at zero, equal average
        send_sample(CH_W'(0), SAMPLE_W'(SAMPLE_TOP));
        send_sample(CH_W'(7), SAMPLE_W'(0));
        send_sample(CH_W'(2), SAMPLE_W'(0));
        repeat (9) send_sample(CH_W'(1), SAMPLE_W'(800));
        send_sample(CH_W'(3), 12'hAAA);
        send_sample(CH_W'(4), 12'h555);
        drain_results();

        // zero band: every average passes through
        configure(0, 1000);
        send_sample(CH_W'(1), SAMPLE_W'(808));
        send_sample(CH_W'(6), SAMPLE_W'(SAMPLE_TOP));
        send_sample(CH_W'(6), SAMPLE_W'(1));
        drain_results();

        // widest band, zero limit: any imbalance steps the held value
        configure(255, 0);
        send_sample(CH_W'(1), SAMPLE_W'(816));
        send_sample(CH_W'(1), SAMPLE_W'(700));
        send_sample(CH_W'(1), SAMPLE_W'(812));
        drain_results();

        configure(40, 120);
        run_phase(300, -1, 0, -10, 30);
        drain_results();

        send_idle_pct = 72;
        recv_idle_pct = 30;
        // drive one channel long enough to saturate its accumulator
        configure(255, 65535);
        run_phase(400, 5, 90, -20, 230);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        band = $urandom_range(1, 64);
        configure(band, $urandom_range(0, 300));
        run_phase(400, -1, 0, -band, band);
        drain_results();

        repeat (12) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
